// ----- hw/rtl/tsl_pkg.sv -----
`default_nettype none

package tsl_pkg;

    // Width of a strip vertex index that takes part in assembly.
    localparam int INDEX_BITS = 32;

    // Width of the index ports and of the vertex limit register.
    localparam int DATA_BITS = 32;

    // Command queue between the front and the back. The depth is a power of two.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [INDEX_BITS-1:0] index_t;

    // An index with all bits set is a primitive restart.
    localparam index_t RESTART_CODE = '1;

    // Number of valid vertices held in the two-entry window.
    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_FULL  = 2'd2
    } fill_t;

    // One unit of work for the back: a triangle or a range error report.
    typedef struct packed {
        logic   is_error;
        index_t first;
        index_t second;
        index_t third;
    } tri_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsl_cmd_queue.sv -----
`default_nettype none

module tsl_cmd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tsl_pkg::tri_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output tsl_pkg::tri_cmd_t      pop_data,
    output logic                   empty
);

    tsl_pkg::tri_cmd_t                    entry_reg [tsl_pkg::QUEUE_DEPTH];
    logic [tsl_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [tsl_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [tsl_pkg::QUEUE_CNT_BITS-1:0]   count_reg;
    logic [tsl_pkg::QUEUE_CNT_BITS-1:0]   count_next;

    assign full     = (count_reg == tsl_pkg::QUEUE_CNT_BITS'(tsl_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Occupancy follows the push and pop strobes.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tsl_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tsl_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tsl_pkg::QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tsl_pkg::QUEUE_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The neighbors must never overrun or underrun the queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/tsl_front.sv -----
`default_nettype none

module tsl_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tsl_pkg::DATA_BITS-1:0] strip_index,
    input  wire logic                          new_list,
    input  wire logic                          cfg_write_en,
    input  wire logic [tsl_pkg::DATA_BITS-1:0] cfg_write_data,
    output logic                               push,
    output tsl_pkg::tri_cmd_t                  push_data,
    input  wire logic                          queue_full
);

    logic [tsl_pkg::DATA_BITS-1:0] vertex_limit_reg;
    tsl_pkg::index_t               older_reg;
    tsl_pkg::index_t               older_next;
    tsl_pkg::index_t               newer_reg;
    tsl_pkg::index_t               newer_next;
    tsl_pkg::fill_t                fill_reg;
    tsl_pkg::fill_t                fill_next;
    logic                          flip_reg;
    logic                          flip_next;
    logic                          error_reg;
    logic                          error_next;

    tsl_pkg::index_t               idx;
    tsl_pkg::fill_t                fill_eff;
    logic                          flip_eff;
    logic                          error_eff;
    logic                          in_fire;
    logic                          out_of_range;
    logic                          degenerate;

    assign in_ready = !queue_full;
    assign in_fire  = in_valid && in_ready;

    // Bits above the index width are ignored.
    assign idx = strip_index[tsl_pkg::INDEX_BITS-1:0];

    // A new list clears the window, the winding and the error before the transaction.
    assign fill_eff  = new_list ? tsl_pkg::FILL_EMPTY : fill_reg;
    assign flip_eff  = new_list ? 1'b0 : flip_reg;
    assign error_eff = new_list ? 1'b0 : error_reg;

    assign out_of_range = (tsl_pkg::DATA_BITS'(idx) >= vertex_limit_reg);
    assign degenerate   = (older_reg == newer_reg) || (newer_reg == idx) || (older_reg == idx);

    // Classify the transaction and advance the window.
    always_comb
    begin
        older_next       = older_reg;
        newer_next       = newer_reg;
        fill_next        = fill_reg;
        flip_next        = flip_reg;
        error_next       = error_reg;
        push             = 1'b0;
        push_data.is_error = 1'b0;
        push_data.first  = flip_eff ? newer_reg : older_reg;
        push_data.second = flip_eff ? older_reg : newer_reg;
        push_data.third  = idx;

        if (in_fire)
        begin
            fill_next  = fill_eff;
            flip_next  = flip_eff;
            error_next = error_eff;
            if (error_eff)
            begin
                // Dropped while the error stays latched.
            end
            else if (idx == tsl_pkg::RESTART_CODE)
            begin
                fill_next = tsl_pkg::FILL_EMPTY;
                flip_next = 1'b0;
            end
            else if (out_of_range)
            begin
                error_next         = 1'b1;
                push               = 1'b1;
                push_data.is_error = 1'b1;
            end
            else
            begin
                unique case (fill_eff)
                    tsl_pkg::FILL_EMPTY:
                    begin
                        older_next = idx;
                        fill_next  = tsl_pkg::FILL_ONE;
                    end
                    tsl_pkg::FILL_ONE:
                    begin
                        newer_next = idx;
                        fill_next  = tsl_pkg::FILL_FULL;
                    end
                    default:
                    begin
                        push       = !degenerate;
                        older_next = newer_reg;
                        newer_next = idx;
                        flip_next  = !flip_eff;
                    end
                endcase
            end
        end
    end

    // List state and the vertex limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_limit_reg <= '0;
            older_reg        <= '0;
            newer_reg        <= '0;
            fill_reg         <= tsl_pkg::FILL_EMPTY;
            flip_reg         <= 1'b0;
            error_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                vertex_limit_reg <= cfg_write_data;
            end
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
            flip_reg  <= flip_next;
            error_reg <= error_next;
        end
    end

    // A latched error silences every transaction that does not start a new list.
    a_latched_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && error_reg && !new_list) |-> !push)
        else $error("command issued while an error was latched");

endmodule

`default_nettype wire

// ----- hw/rtl/tsl_back.sv -----
`default_nettype none

module tsl_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tsl_pkg::tri_cmd_t             pop_data,
    input  wire logic                          queue_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tsl_pkg::DATA_BITS-1:0]      vertex_index,
    output logic                               range_error,
    output logic                               triangle_end
);

    typedef enum logic [1:0] {
        BEAT_FIRST,
        BEAT_SECOND,
        BEAT_THIRD
    } beat_t;

    beat_t              beat_reg;
    tsl_pkg::tri_cmd_t  cmd_reg;
    logic               busy_reg;
    logic               out_fire;
    logic               last_beat;
    tsl_pkg::index_t    beat_vertex;

    assign out_fire  = busy_reg && out_ready;
    assign last_beat = cmd_reg.is_error || (beat_reg == BEAT_THIRD);

    // Take the next command as soon as the current one finishes.
    assign pop = (!busy_reg || (out_fire && last_beat)) && !queue_empty;

    // Select the vertex for the current beat.
    always_comb
    begin
        unique case (beat_reg)
            BEAT_FIRST:  beat_vertex = cmd_reg.first;
            BEAT_SECOND: beat_vertex = cmd_reg.second;
            BEAT_THIRD:  beat_vertex = cmd_reg.third;
            default:     beat_vertex = cmd_reg.third;
        endcase
    end

    assign out_valid    = busy_reg;
    assign vertex_index = cmd_reg.is_error ? '0 : tsl_pkg::DATA_BITS'(beat_vertex);
    assign range_error  = cmd_reg.is_error;
    assign triangle_end = last_beat;

    // Beat sequencer and command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= BEAT_FIRST;
            busy_reg <= 1'b0;
            cmd_reg  <= '0;
        end
        else if (pop)
        begin
            cmd_reg  <= pop_data;
            busy_reg <= 1'b1;
            beat_reg <= BEAT_FIRST;
        end
        else if (out_fire)
        begin
            if (last_beat)
            begin
                busy_reg <= 1'b0;
                beat_reg <= BEAT_FIRST;
            end
            else
            begin
                unique case (beat_reg)
                    BEAT_FIRST:  beat_reg <= BEAT_SECOND;
                    BEAT_SECOND: beat_reg <= BEAT_THIRD;
                    default:     beat_reg <= BEAT_FIRST;
                endcase
            end
        end
    end

    // An error report is a single result that carries a zero vertex.
    a_error_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (triangle_end && vertex_index == '0))
        else $error("range error result is not a single zero-vertex result");

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_strip_to_list_core.sv -----
`default_nettype none

// A result-bearing transaction moves its command through the queue into the back's command
// register before its first result shows. Throughput: one input per cycle while the queue
// has room; a triangle gives three results on the one-wide result port, an error report one.
// Reset clears the window, winding, error latch, queue and vertex limit (to zero) at once.
module triangle_strip_to_list_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tsl_pkg::DATA_BITS-1:0] strip_index,
    input  wire logic                          new_list,
    input  wire logic                          cfg_write_en,
    input  wire logic [tsl_pkg::DATA_BITS-1:0] cfg_write_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tsl_pkg::DATA_BITS-1:0]      vertex_index,
    output logic                               range_error,
    output logic                               triangle_end
);

    tsl_pkg::tri_cmd_t push_data;
    tsl_pkg::tri_cmd_t pop_data;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;

    // Front: accepts strip indices and builds triangle commands.
    tsl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .strip_index    (strip_index),
        .new_list       (new_list),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push),
        .push_data      (push_data),
        .queue_full     (queue_full)
    );

    // Queue decouples the two sides.
    tsl_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Back: emits each command as one or three results.
    tsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_data     (pop_data),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .range_error  (range_error),
        .triangle_end (triangle_end)
    );

endmodule

`default_nettype wire
